FILE: design/qdec_pkg.sv
// ----------------------------------------------------------------------------
// qdec_pkg
// Shared types and constants of the quadrature decoder with acceleration.
// ----------------------------------------------------------------------------
`default_nettype none

package qdec_pkg;

	// commands
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_SCAN  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] REG_DETENT_PULSES   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_ENABLE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_INCREMENT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_DECREMENT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_TOP       = 3'd4;

	// register reset values
	localparam logic [2:0]  RST_DETENT_PULSES   = 3'd2;
	localparam logic        RST_ACCEL_ENABLE    = 1'b1;
	localparam logic [7:0]  RST_ACCEL_INCREMENT = 8'd25;
	localparam logic [7:0]  RST_ACCEL_DECREMENT = 8'd2;
	localparam logic [14:0] RST_ACCEL_TOP       = 15'd3072;

	// pulses per detent codes that divide
	localparam logic [2:0] PPS_TWO  = 3'd2;
	localparam logic [2:0] PPS_FOUR = 3'd4;

	localparam int MOTION_W = 9;
	localparam int COUNT_W  = 16;
	localparam int ACCEL_W  = 16;

	typedef struct packed {
		logic [2:0]  detent_pulses;
		logic        accel_enable;
		logic [7:0]  accel_increment;
		logic [7:0]  accel_decrement;
		logic [14:0] accel_top;
	} cfg_t;

endpackage

`default_nettype wire

FILE: design/qdec_if.sv
// ----------------------------------------------------------------------------
// qdec channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface qdec_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic       pin_a;
	logic       pin_b;

	modport source (output valid, output cmd, output pin_a, output pin_b, input ready);
	modport sink   (input valid, input cmd, input pin_a, input pin_b, output ready);
endinterface

interface qdec_out_if;
	logic              valid;
	logic              ready;
	logic signed [8:0] motion;
	logic              moved;

	modport source (output valid, output motion, output moved, input ready);
	modport sink   (input valid, input motion, input moved, output ready);
endinterface

`default_nettype wire

FILE: design/qdec_cfg.sv
// ----------------------------------------------------------------------------
// qdec_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module qdec_cfg
	import qdec_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.detent_pulses   <= RST_DETENT_PULSES;
			cfg_q.accel_enable    <= RST_ACCEL_ENABLE;
			cfg_q.accel_increment <= RST_ACCEL_INCREMENT;
			cfg_q.accel_decrement <= RST_ACCEL_DECREMENT;
			cfg_q.accel_top       <= RST_ACCEL_TOP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DETENT_PULSES:   cfg_q.detent_pulses   <= cfg_data[2:0];
				REG_ACCEL_ENABLE:    cfg_q.accel_enable    <= cfg_data[0];
				REG_ACCEL_INCREMENT: cfg_q.accel_increment <= cfg_data[7:0];
				REG_ACCEL_DECREMENT: cfg_q.accel_decrement <= cfg_data[7:0];
				REG_ACCEL_TOP:       cfg_q.accel_top       <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: design/qdec_core.sv
// ----------------------------------------------------------------------------
// qdec_core
// Decoder state (phase, pulse count, acceleration) and the per-item logic.
// ----------------------------------------------------------------------------
`default_nettype none

module qdec_core
	import qdec_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 fire,
	input  wire logic [1:0]           cmd,
	input  wire logic                 pin_a,
	input  wire logic                 pin_b,
	input  wire cfg_t                 cfg,
	output logic signed [MOTION_W-1:0] motion,
	output logic                      moved
);

	logic [1:0]         phase_q;
	logic [COUNT_W-1:0] count_q;
	logic [ACCEL_W-1:0] accel_q;

	logic [1:0]         phase_d;
	logic [COUNT_W-1:0] count_d;
	logic [ACCEL_W-1:0] accel_d;

	logic [1:0]          curr;
	logic [1:0]          diff;
	logic [ACCEL_W-1:0]  decayed;
	logic [ACCEL_W-1:0]  accel_mid;
	logic signed [17:0]  room;
	logic                nonzero;
	logic [MOTION_W-1:0] scale;

	assign curr = {pin_b, pin_b ^ pin_a};
	assign diff = phase_q - curr;
	assign decayed = accel_q - {8'd0, cfg.accel_decrement};
	assign accel_mid = !cfg.accel_enable ? accel_q : (decayed[ACCEL_W-1] ? '0 : decayed);
	assign room = $signed({3'd0, cfg.accel_top}) - $signed({10'd0, cfg.accel_increment});
	assign scale = {1'b0, (cfg.accel_enable ? accel_q[15:8] : 8'd0)} + 9'd1;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		accel_d = accel_q;
		motion  = '0;
		moved   = 1'b0;
		nonzero = 1'b0;
		case (cmd)
			CMD_START: phase_d = curr;
			CMD_SCAN: begin
				accel_d = accel_mid;
				if (diff[0]) begin
					phase_d = curr;
					count_d = count_q + (diff[1] ? 16'h0001 : 16'hFFFF);
					moved   = 1'b1;
					if (cfg.accel_enable && ($signed({2'd0, accel_mid}) <= room)) begin
						accel_d = accel_mid + {8'd0, cfg.accel_increment};
					end
				end
			end
			CMD_READ: begin
				case (cfg.detent_pulses)
					PPS_TWO: begin
						nonzero = |count_q[15:1];
						count_d = {15'd0, count_q[0]};
					end
					PPS_FOUR: begin
						nonzero = |count_q[15:2];
						count_d = {14'd0, count_q[1:0]};
					end
					default: begin
						nonzero = |count_q;
						count_d = '0;
					end
				endcase
				if (count_q[COUNT_W-1]) begin
					motion = $signed(-scale);
				end else if (nonzero) begin
					motion = $signed(scale);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			count_q <= '0;
			accel_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			count_q <= count_d;
			accel_q <= accel_d;
		end
	end

endmodule

`default_nettype wire

FILE: design/quadrature_decoder_with_accel.sv
// ----------------------------------------------------------------------------
// quadrature_decoder_with_accel
// Rotary quadrature encoder decoder with start, scan and read commands.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result register is not stalled, and
// returns one result per item, in order. An item is held in an input register,
// then decoded against the phase, pulse count and acceleration state and
// written to the result register, from which it can transfer out. The rate of
// one item per clock is set by the update of the decoder state, which the next
// item reads. A stalled result register holds the input register. Configuration
// writes take effect on the next cycle and are meant for an idle block.
`default_nettype none

module quadrature_decoder_with_accel
	import qdec_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	qdec_in_if.sink                    in_ch,
	qdec_out_if.source                 out_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;

	logic       v_s1;
	logic [1:0] cmd_s1;
	logic       a_s1;
	logic       b_s1;

	logic                       v_s2;
	logic signed [MOTION_W-1:0] motion_s2;
	logic                       moved_s2;

	logic                       advance;
	logic signed [MOTION_W-1:0] motion;
	logic                       moved;

	qdec_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	qdec_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.cmd    (cmd_s1),
		.pin_a  (a_s1),
		.pin_b  (b_s1),
		.cfg    (cfg),
		.motion (motion),
		.moved  (moved)
	);

	assign advance = v_s1 && (!v_s2 || out_ch.ready);
	assign in_ch.ready = !v_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_s1 <= in_ch.cmd;
			a_s1   <= in_ch.pin_a;
			b_s1   <= in_ch.pin_b;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || out_ch.ready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			motion_s2 <= motion;
			moved_s2  <= moved;
		end
	end

	assign out_ch.valid  = v_s2;
	assign out_ch.motion = motion_s2;
	assign out_ch.moved  = moved_s2;

endmodule

`default_nettype wire

FILE: design/qdec_checker.sv
// ----------------------------------------------------------------------------
// qdec_checker
// Port-level checks of the quadrature decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qdec_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [8:0] out_motion,
	input wire logic       out_moved
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_motion) && $stable(out_moved))
	else $error("stalled result changed");

	// a scan result never carries motion
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_moved |-> out_motion == 9'd0)
	else $error("moved and motion both set");

	// transfer into an empty block reaches the output unless the result register is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid ##1 out_ready |=> out_valid)
	else $error("result late");

	// no result during reset
	assert property (@(posedge clk) !arst_n |-> !out_valid)
	else $error("result valid in reset");

endmodule

bind quadrature_decoder_with_accel qdec_checker u_qdec_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_motion (out_ch.motion),
	.out_moved  (out_ch.moved)
);

`default_nettype wire

FILE: verif/tb_quadrature_decoder_with_accel.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadrature_decoder_with_accel
// Drives start, scan and read transfers built from a simulated knob into the
// decoder and checks every motion report against an in-bench decoder model.
// The run walks several register settings and three pacing modes.
// ----------------------------------------------------------------------------

module tb_quadrature_decoder_with_accel;
	import qdec_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD = 400;
	localparam int SEGMENTS = 6;

	typedef enum logic [1:0] {PACE_RECV_SLOW, PACE_SEND_SLOW, PACE_FULL} pace_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       pin_a;
		logic       pin_b;
	} sample_t;

	typedef struct packed {
		logic signed [MOTION_W-1:0] motion;
		logic                       moved;
	} report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	qdec_in_if in_ch();
	qdec_out_if out_ch();

	quadrature_decoder_with_accel dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	sample_t encoder_samples[$];
	report_t expected_reports[$];
	sample_t next_sample;
	report_t got_report;
	report_t want_report;
	pace_t pace = PACE_RECV_SLOW;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	// decoder model state
	cfg_t cfg_now = '{RST_DETENT_PULSES, RST_ACCEL_ENABLE, RST_ACCEL_INCREMENT,
		RST_ACCEL_DECREMENT, RST_ACCEL_TOP};
	logic [1:0] dec_phase = '0;
	logic signed [COUNT_W-1:0] dec_count = '0;
	logic [ACCEL_W-1:0] dec_accel = '0;

	// stimulus knob
	logic [1:0] knob_pos = '0;
	logic knob_fwd = 1'b1;

	function automatic report_t decode_sample(sample_t s);
		report_t r;
		logic [1:0] pin_phase;
		logic [1:0] diff;
		logic signed [COUNT_W-1:0] whole;
		int scale;
		r.motion = '0;
		r.moved = 1'b0;
		pin_phase = {s.pin_b, s.pin_b ^ s.pin_a};
		case (s.cmd)
			CMD_START: begin
				dec_phase = pin_phase;
			end
			CMD_SCAN: begin
				diff = dec_phase - pin_phase;
				if (cfg_now.accel_enable) begin
					dec_accel = dec_accel - ACCEL_W'(cfg_now.accel_decrement);
					if (dec_accel[ACCEL_W-1])
						dec_accel = '0;
				end
				if (diff[0]) begin
					dec_phase = pin_phase;
					dec_count = diff[1] ? dec_count + 16'sd1 : dec_count - 16'sd1;
					r.moved = 1'b1;
				end
				if (r.moved && cfg_now.accel_enable && int'(dec_accel) <=
						int'(cfg_now.accel_top) - int'(cfg_now.accel_increment))
					dec_accel = dec_accel + ACCEL_W'(cfg_now.accel_increment);
			end
			CMD_READ: begin
				case (cfg_now.detent_pulses)
					PPS_TWO: begin
						whole = dec_count >>> 1;
						dec_count = dec_count & 16'sd1;
					end
					PPS_FOUR: begin
						whole = dec_count >>> 2;
						dec_count = dec_count & 16'sd3;
					end
					default: begin
						whole = dec_count;
						dec_count = '0;
					end
				endcase
				scale = 1 + (cfg_now.accel_enable ? int'(dec_accel[15:8]) : 0);
				if (whole < 0)
					r.motion = MOTION_W'(-scale);
				else if (whole > 0)
					r.motion = MOTION_W'(scale);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// sender
	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			expected_reports.push_back(decode_sample({in_ch.cmd, in_ch.pin_a, in_ch.pin_b}));
		if (!(in_ch.valid && !in_ch.ready)) begin
			if (encoder_samples.size() > 0 && $urandom_range(99) >=
					(pace == PACE_RECV_SLOW ? 26 : pace == PACE_SEND_SLOW ? 70 : 0)) begin
				next_sample = encoder_samples.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.cmd <= next_sample.cmd;
				in_ch.pin_a <= next_sample.pin_a;
				in_ch.pin_b <= next_sample.pin_b;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			got_report = {out_ch.motion, out_ch.moved};
			if (expected_reports.size() == 0) begin
				$display("%0t unexpected transfer: motion %0d moved %0d", $time,
					got_report.motion, got_report.moved);
				mismatch_count++;
			end else begin
				want_report = expected_reports.pop_front();
				if (got_report.motion !== want_report.motion) begin
					$display("%0t motion: expected %0d, actual %0d", $time,
						want_report.motion, got_report.motion);
					mismatch_count++;
				end
				if (got_report.moved !== want_report.moved) begin
					$display("%0t moved: expected %0d, actual %0d", $time,
						want_report.moved, got_report.moved);
					mismatch_count++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (pace == PACE_FULL && !hold_done) begin
			hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= $urandom_range(99) >=
				(pace == PACE_RECV_SLOW ? 70 : pace == PACE_SEND_SLOW ? 26 : 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_sample(input logic [1:0] cmd, input logic a, input logic b);
		encoder_samples.push_back('{cmd, a, b});
	endtask

	task automatic queue_knob_traffic(input int n, input int read_pct);
		int counted;
		int r;
		logic [1:0] p;
		sample_t s;
		counted = 0;
		while (counted < n) begin
			r = $urandom_range(99);
			p = 2'($urandom_range(3));
			if (r < 5) begin
				s.cmd = CMD_START;
				knob_pos = p;
			end else if (r < 5 + read_pct) begin
				s.cmd = CMD_READ;
			end else if (r < 8 + read_pct) begin
				s.cmd = CMD_NOP;
			end else begin
				s.cmd = CMD_SCAN;
				if ($urandom_range(19) == 0)
					knob_fwd = ~knob_fwd;
				r = $urandom_range(99);
				if (r < 55)
					p = knob_fwd ? knob_pos + 2'd1 : knob_pos - 2'd1;
				else if (r < 75)
					p = knob_pos;
				else if (r < 85)
					p = knob_fwd ? knob_pos - 2'd1 : knob_pos + 2'd1;
				else if (r < 93)
					p = knob_pos + 2'd2;
				if (p[0] != knob_pos[0])
					knob_pos = p;
			end
			s.pin_b = p[1];
			s.pin_a = p[0] ^ p[1];
			encoder_samples.push_back(s);
			if (s.cmd != CMD_NOP)
				counted++;
		end
	endtask

	// checked between edges so that the queues and the offer have settled
	task automatic wait_idle();
		@(negedge clk);
		while (encoder_samples.size() != 0 || expected_reports.size() != 0 || in_ch.valid)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_t c);
		cfg_we <= 1'b1;
		cfg_index <= REG_DETENT_PULSES;
		cfg_data <= CFG_DATA_W'(c.detent_pulses);
		@(posedge clk);
		cfg_index <= REG_ACCEL_ENABLE;
		cfg_data <= CFG_DATA_W'(c.accel_enable);
		@(posedge clk);
		cfg_index <= REG_ACCEL_INCREMENT;
		cfg_data <= CFG_DATA_W'(c.accel_increment);
		@(posedge clk);
		cfg_index <= REG_ACCEL_DECREMENT;
		cfg_data <= CFG_DATA_W'(c.accel_decrement);
		@(posedge clk);
		cfg_index <= REG_ACCEL_TOP;
		cfg_data <= c.accel_top;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_now = c;
		@(posedge clk);
	endtask

	initial begin
		cfg_t plan[SEGMENTS];
		int read_pct[SEGMENTS];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_NOP;
		in_ch.pin_a = 1'b0;
		in_ch.pin_b = 1'b0;
		out_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: pin phases, both directions, two-step jump, negative read
		push_sample(CMD_READ, 1'b0, 1'b0);
		push_sample(CMD_NOP, 1'b1, 1'b1);
		push_sample(CMD_START, 1'b1, 1'b1);
		push_sample(CMD_START, 1'b0, 1'b0);
		push_sample(CMD_SCAN, 1'b0, 1'b0);
		push_sample(CMD_SCAN, 1'b1, 1'b0);
		push_sample(CMD_SCAN, 1'b1, 1'b1);
		push_sample(CMD_SCAN, 1'b0, 1'b1);
		push_sample(CMD_READ, 1'b0, 1'b0);
		push_sample(CMD_SCAN, 1'b1, 1'b0);
		push_sample(CMD_SCAN, 1'b1, 1'b1);
		push_sample(CMD_SCAN, 1'b1, 1'b0);
		push_sample(CMD_SCAN, 1'b0, 1'b0);
		push_sample(CMD_SCAN, 1'b0, 1'b1);
		push_sample(CMD_READ, 1'b1, 1'b1);
		push_sample(CMD_READ, 1'b0, 1'b1);
		push_sample(CMD_START, 1'b1, 1'b0);
		push_sample(CMD_NOP, 1'b0, 1'b1);
		push_sample(CMD_SCAN, 1'b1, 1'b0);
		push_sample(CMD_NOP, 1'b1, 1'b0);
		wait_idle();
		knob_pos = dec_phase;

		plan[0] = '{3'd4, 1'b1, 8'd255, 8'd0, 15'd32767};
		plan[1] = '{3'd1, 1'b1, 8'd25, 8'd2, 15'd3072};
		plan[2] = '{3'd2, 1'b0, 8'd100, 8'd50, 15'd1000};
		plan[3] = '{3'd0, 1'b1, 8'd200, 8'd255, 15'd100};
		plan[4] = '{3'd7, 1'b1, 8'd0, 8'd1, 15'd0};
		plan[5] = '{3'($urandom_range(7)), 1'b1, 8'($urandom_range(255)),
			8'($urandom_range(8)), 15'($urandom_range(32767))};
		read_pct = '{20, 3, 15, 25, 10, 20};

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			pace <= seg < 2 ? PACE_RECV_SLOW : seg < 4 ? PACE_SEND_SLOW : PACE_FULL;
			write_cfg(plan[seg]);
			queue_knob_traffic(285, read_pct[seg]);
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_reports.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: quadrature_decoder_with_accel.f
design/qdec_pkg.sv
design/qdec_if.sv
design/qdec_cfg.sv
design/qdec_core.sv
design/quadrature_decoder_with_accel.sv
design/qdec_checker.sv
verif/tb_quadrature_decoder_with_accel.sv
